>>> design/ccfd_pkg.sv
// ============================================================================
// ccfd_pkg - shared types and constants of the crc checked frame deframer
// frame layout positions, crc-16/xmodem constants, result kind codes
// ============================================================================
package ccfd_pkg;

    localparam int POS_W   = 18;
    localparam int CRC_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 18;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // crc-16/xmodem
    localparam crc_t CRC_POLY = 16'h1021;
    localparam crc_t CRC_INIT = 16'h0000;

    // byte positions inside a frame
    localparam pos_t POS_LEN_LO   = 18'd2;
    localparam pos_t POS_LEN_HI   = 18'd3;
    localparam pos_t POS_RW_LO    = 18'd10;
    localparam pos_t POS_RW_HI    = 18'd11;
    localparam pos_t POS_CRC_LO   = 18'd12;
    localparam pos_t POS_CRC_HI   = 18'd13;
    localparam pos_t POS_CLS_LO   = 18'd14;
    localparam pos_t POS_CLS_HI   = 18'd15;
    localparam pos_t POS_ADDR_0   = 18'd16;
    localparam pos_t POS_ADDR_1   = 18'd17;
    localparam pos_t POS_ADDR_2   = 18'd18;
    localparam pos_t POS_ADDR_3   = 18'd19;
    localparam pos_t HEADER_BYTES = 18'd20;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } kind_t;

endpackage

>>> design/ccfd_crc16_byte.sv
// ============================================================================
// ccfd_crc16_byte - one byte step of crc-16/xmodem
// msb first, no reflection, eight shift steps on a 16-bit value
// ============================================================================
module ccfd_crc16_byte
    import ccfd_pkg::*;
(
    input  crc_t  crc_in,
    input  byte_t data_in,
    output crc_t  crc_out
);

    always_comb begin
        crc_t c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

>>> design/crc_checked_frame_deframer.sv
// ============================================================================
// crc_checked_frame_deframer - length prefixed frame parser with crc check
// parses back-to-back little-endian frames, checks the header crc and emits
// header, payload byte and error transactions
// ============================================================================
// results are registered: each appears on m_* in the cycle after the byte that causes it
// throughput: one byte per cycle while s_ready is high; the crc byte step and counters sit between
//   the frame state registers and the output register
// s_ready drops only while a result waits in the output register unaccepted
// reset: synchronous active-low aresetn clears position, crc, flags and valid
// after a length error the block swallows all bytes silently until reset
module crc_checked_frame_deframer
    import ccfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // results out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_rw_word,
    output logic [3:0]  m_class_code,
    output logic [11:0] m_burst_words,
    output logic [31:0] m_address,
    output logic [7:0]  m_payload_byte,
    output logic        m_last
);

    // frame state
    pos_t          pos_reg,        pos_next;
    pos_t          frame_bytes_reg, frame_bytes_next;
    crc_t          crc_reg,        crc_next;
    crc_t          rx_crc_reg,     rx_crc_next;
    logic [15:0]   rw_reg,         rw_next;
    logic [15:0]   cls_reg,        cls_next;
    logic [23:0]   addr_reg,       addr_next;
    logic [LIMIT_W-1:0] remain_reg, remain_next;
    logic          discard_reg,    discard_next;
    logic          halted_reg,     halted_next;

    // output register
    logic          out_valid_reg,  out_valid_next;
    kind_t         kind_reg,       kind_next;
    logic [15:0]   orw_reg,        orw_next;
    logic [3:0]    ocls_reg,       ocls_next;
    logic [11:0]   oburst_reg,     oburst_next;
    logic [31:0]   oaddr_reg,      oaddr_next;
    logic [7:0]    odata_reg,      odata_next;
    logic          olast_reg,      olast_next;

    logic          accept;
    logic          out_free;
    crc_t          crc_upd;
    logic          crc_cover;
    logic          frame_end;
    logic [13:0]   burst_bytes;
    logic [LIMIT_W-1:0] avail;
    logic [LIMIT_W-1:0] limit;

    // output slot frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = out_free;
    assign accept   = s_valid && s_ready;

    ccfd_crc16_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (s_rx_byte),
        .crc_out (crc_upd)
    );

    // crc covers bytes 0..11 and 14..15
    assign crc_cover = (pos_reg < POS_CRC_LO) || (pos_reg == POS_CLS_LO)
                    || (pos_reg == POS_CLS_HI);

    // payload window: min(burst*4, frame length - header)
    assign burst_bytes = {cls_reg[15:4], 2'b00};
    assign avail       = frame_bytes_reg - HEADER_BYTES;
    assign limit       = ({4'd0, burst_bytes} < avail) ? {4'd0, burst_bytes} : avail;

    // last byte of the frame, from the last header byte on
    assign frame_end = (pos_reg >= POS_ADDR_3)
                    && (({1'b0, pos_reg} + 19'd1) >= {1'b0, frame_bytes_reg});

    always_comb begin
        pos_next         = pos_reg;
        frame_bytes_next = frame_bytes_reg;
        crc_next         = crc_reg;
        rx_crc_next      = rx_crc_reg;
        rw_next          = rw_reg;
        cls_next         = cls_reg;
        addr_next        = addr_reg;
        remain_next      = remain_reg;
        discard_next     = discard_reg;
        halted_next      = halted_reg;

        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        orw_next       = orw_reg;
        ocls_next      = ocls_reg;
        oburst_next    = oburst_reg;
        oaddr_next     = oaddr_reg;
        odata_next     = odata_reg;
        olast_next     = olast_reg;

        if (accept && !halted_reg) begin
            if (crc_cover) begin
                crc_next = crc_upd;
            end

            // capture header fields, little-endian
            unique case (pos_reg)
                POS_LEN_LO: frame_bytes_next = {10'd0, s_rx_byte};
                POS_LEN_HI: frame_bytes_next = {s_rx_byte, frame_bytes_reg[7:0], 2'b00};
                POS_RW_LO:  rw_next     = {8'd0, s_rx_byte};
                POS_RW_HI:  rw_next     = {s_rx_byte, rw_reg[7:0]};
                POS_CRC_LO: rx_crc_next = {8'd0, s_rx_byte};
                POS_CRC_HI: rx_crc_next = {s_rx_byte, rx_crc_reg[7:0]};
                POS_CLS_LO: cls_next    = {8'd0, s_rx_byte};
                POS_CLS_HI: cls_next    = {s_rx_byte, cls_reg[7:0]};
                POS_ADDR_0: addr_next   = {16'd0, s_rx_byte};
                POS_ADDR_1: addr_next   = {8'd0, s_rx_byte, addr_reg[7:0]};
                POS_ADDR_2: addr_next   = {s_rx_byte, addr_reg[15:0]};
                default: ;
            endcase

            // default result fields are zero
            kind_next   = KIND_HEADER;
            orw_next    = '0;
            ocls_next   = '0;
            oburst_next = '0;
            oaddr_next  = '0;
            odata_next  = '0;
            olast_next  = 1'b0;

            if (pos_reg == POS_CLS_HI) begin
                if (frame_bytes_reg < HEADER_BYTES) begin
                    // length too short: report and stop until reset
                    out_valid_next = 1'b1;
                    kind_next      = KIND_LEN_ERR;
                    olast_next     = 1'b1;
                    halted_next    = 1'b1;
                end else if (crc_upd != rx_crc_reg) begin
                    // crc mismatch: report and skip the rest of the frame
                    out_valid_next = 1'b1;
                    kind_next      = KIND_CRC_ERR;
                    olast_next     = 1'b1;
                    discard_next   = 1'b1;
                end
            end

            if (pos_reg == POS_ADDR_3) begin
                remain_next = limit;
                if (!discard_reg) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_HEADER;
                    orw_next       = rw_reg;
                    ocls_next      = cls_reg[3:0];
                    oburst_next    = cls_reg[15:4];
                    oaddr_next     = {s_rx_byte, addr_reg};
                    olast_next     = (limit == '0);
                end
            end else if (pos_reg >= HEADER_BYTES && !discard_reg && remain_reg != '0) begin
                out_valid_next = 1'b1;
                kind_next      = KIND_PAYLOAD;
                odata_next     = s_rx_byte;
                olast_next     = (remain_reg == LIMIT_W'(1));
                remain_next    = remain_reg - LIMIT_W'(1);
            end

            // advance, or rewind at the end of the frame
            if (frame_end) begin
                pos_next     = '0;
                crc_next     = CRC_INIT;
                discard_next = 1'b0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            frame_bytes_reg <= '0;
            crc_reg         <= CRC_INIT;
            rx_crc_reg      <= '0;
            rw_reg          <= '0;
            cls_reg         <= '0;
            addr_reg        <= '0;
            remain_reg      <= '0;
            discard_reg     <= 1'b0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            frame_bytes_reg <= frame_bytes_next;
            crc_reg         <= crc_next;
            rx_crc_reg      <= rx_crc_next;
            rw_reg          <= rw_next;
            cls_reg         <= cls_next;
            addr_reg        <= addr_next;
            remain_reg      <= remain_next;
            discard_reg     <= discard_next;
            halted_reg      <= halted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        orw_reg    <= orw_next;
        ocls_reg   <= ocls_next;
        oburst_reg <= oburst_next;
        oaddr_reg  <= oaddr_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = kind_reg;
    assign m_rw_word      = orw_reg;
    assign m_class_code   = ocls_reg;
    assign m_burst_words  = oburst_reg;
    assign m_address      = oaddr_reg;
    assign m_payload_byte = odata_reg;
    assign m_last         = olast_reg;

`ifndef NO_ASSERTIONS
    // once halted, only reset leaves that state
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped without reset");

    // halted with an empty output slot never produces a transaction
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg && !out_valid_reg |=> !out_valid_reg)
        else $error("result produced while halted");

    // error transactions always close the frame
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (kind_reg == KIND_CRC_ERR || kind_reg == KIND_LEN_ERR)
        |-> olast_reg)
        else $error("error transaction without last");

    // a skipped frame never emits payload bytes
    a_discard_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && discard_reg && !halted_reg |=> !(out_valid_reg && kind_reg == KIND_PAYLOAD))
        else $error("payload emitted from a discarded frame");
`endif

endmodule
